>>> rtl/core/pisc_pkg.sv
// Shared widths, constants, register codes and the configuration type of the speed controller.
package pisc_pkg;

    // Fixed field widths
    localparam int SPEED_W    = 20;
    localparam int GAIN_W     = 24;
    localparam int PULSE_W    = 20;
    localparam int TICKS_W    = 8;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // Speed scaling and effort format
    localparam int SPEED_FRAC_BITS = 8;
    localparam int GAIN_SHIFT      = 8 + SPEED_FRAC_BITS;
    localparam int EFFORT_FRAC     = 16;
    localparam int EFFORT_W        = 17;
    localparam logic [EFFORT_W-1:0] EFFORT_ONE      = 17'd65536;
    localparam logic [EFFORT_W-1:0] KICK_EFFORT_MIN = 17'd3276;
    localparam logic [SPEED_W-1:0]  MOVING_LIMIT    = SPEED_W'(5 << SPEED_FRAC_BITS);

    // Bit-serial multiplier geometry
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 20;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Default drive width
    localparam int DEF_DRIVE_WIDTH = 21;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_PULSE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_TICKS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP     = 3'd6;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 24'd67109;
    localparam logic [GAIN_W-1:0]  RST_INTEGRAL_STEP = 24'd16777;
    localparam logic [PULSE_W-1:0] RST_PULSE_OFFSET  = 20'd700000;
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX     = 20'd1000000;
    localparam logic [PULSE_W-1:0] RST_KICK_PULSE    = 20'd1000000;
    localparam logic [TICKS_W-1:0] RST_KICK_TICKS    = 8'd20;
    localparam logic [PULSE_W-1:0] RST_SLEW_STEP     = 20'd8000;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integral_step;
        logic [PULSE_W-1:0] pulse_offset;
        logic [PULSE_W-1:0] pulse_max;
        logic [PULSE_W-1:0] kick_pulse;
        logic [TICKS_W-1:0] kick_ticks;
        logic [PULSE_W-1:0] slew_step;
    } t_cfg;

endpackage

>>> rtl/core/pisc_cfg_regs.sv
// Configuration register bank of the speed controller.
module pisc_cfg_regs
    import pisc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= RST_PROP_GAIN;
            r_cfg.integral_step <= RST_INTEGRAL_STEP;
            r_cfg.pulse_offset  <= RST_PULSE_OFFSET;
            r_cfg.pulse_max     <= RST_PULSE_MAX;
            r_cfg.kick_pulse    <= RST_KICK_PULSE;
            r_cfg.kick_ticks    <= RST_KICK_TICKS;
            r_cfg.slew_step     <= RST_SLEW_STEP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_STEP: r_cfg.integral_step <= i_cfg_data[GAIN_W-1:0];
                CFG_PULSE_OFFSET:  r_cfg.pulse_offset  <= i_cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX:     r_cfg.pulse_max     <= i_cfg_data[PULSE_W-1:0];
                CFG_KICK_PULSE:    r_cfg.kick_pulse    <= i_cfg_data[PULSE_W-1:0];
                CFG_KICK_TICKS:    r_cfg.kick_ticks    <= i_cfg_data[TICKS_W-1:0];
                CFG_SLEW_STEP:     r_cfg.slew_step     <= i_cfg_data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/pisc_serial_mult.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module pisc_serial_mult
    import pisc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic               o_done,
    output logic [MUL_P_W-1:0] o_prod
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_A_W-1:0]   r_hi;
    logic [MUL_B_W-1:0]   r_lo;
    logic [MUL_A_W:0]     w_sum;
    logic                 w_last;

    // partial sum: high half plus multiplicand when the current bit is set
    assign w_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(MUL_A_W+1){1'b0}});
    assign w_last = (r_cnt == MUL_CNT_W'(MUL_B_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum[MUL_A_W:1];
            r_lo <= {w_sum[0], r_lo[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

>>> rtl/core/pi_speed_controller_slew_unit.sv
// Top level of the PI speed controller with kick-start and slew-limited drive.
//
// One request per control tick carries a signed target speed and a signed
// measured speed (both Q8 rpm) plus a fresh-sample flag; one result comes back
// with the signed pulse-width drive in ns and the slew and kick flags. The
// block works on one request at a time. The shared bit-serial multiplier
// forms up to three products in turn (proportional term, deadzone map,
// integral term); a zero target skips all three. The result sits in an
// output register, so the next request is taken while the previous result
// still waits on m_axis_tready. Configuration writes land at once and are
// meant for idle periods only. The integrator, kick counter, was-stopped
// flag and last drive are cleared by reset to zero, zero, one and zero.
module pi_speed_controller_slew_unit
    import pisc_pkg::*;
#(
    parameter int DRIVE_WIDTH = DEF_DRIVE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,   // [19:0] target_speed, [39:20] measured_speed
    input  logic [0:0]            s_axis_tuser,   // [0] speed_fresh
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [((DRIVE_WIDTH+7)/8)*8-1:0] m_axis_tdata, // [DRIVE_WIDTH-1:0] drive
    output logic [1:0]            m_axis_tuser    // [0] slew_limited, [1] kicking
);

    localparam int OUT_TDATA_W = ((DRIVE_WIDTH + 7) / 8) * 8;
    // slew arithmetic width: covers last drive plus or minus one step
    localparam int LW = ((DRIVE_WIDTH > PULSE_W + 1) ? DRIVE_WIDTH : PULSE_W + 1) + 2;
    // proportional / integral term width after the gain shift
    localparam int PW = MUL_P_W - GAIN_SHIFT + 1;
    localparam int SW = PW + 1;
    localparam int TW = PULSE_W + 1;
    localparam int UW = PULSE_W + 2;

    localparam logic signed [LW-1:0] DMAX  = (LW'(1) << (DRIVE_WIDTH - 1)) - LW'(1);
    localparam logic signed [LW-1:0] NDMAX = -DMAX;
    localparam logic signed [SW-1:0] EFF_ONE_S = SW'(EFFORT_ONE);

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_ABS     = 5'd1;
    localparam logic [4:0] S_ERR     = 5'd2;
    localparam logic [4:0] S_MP_GO   = 5'd3;
    localparam logic [4:0] S_MP_WAIT = 5'd4;
    localparam logic [4:0] S_PFIX    = 5'd5;
    localparam logic [4:0] S_EVAL    = 5'd6;
    localparam logic [4:0] S_KICK    = 5'd7;
    localparam logic [4:0] S_MU_GO   = 5'd8;
    localparam logic [4:0] S_MU_WAIT = 5'd9;
    localparam logic [4:0] S_UFIX    = 5'd10;
    localparam logic [4:0] S_UADD    = 5'd11;
    localparam logic [4:0] S_CMD     = 5'd12;
    localparam logic [4:0] S_SLEW    = 5'd13;
    localparam logic [4:0] S_SAT     = 5'd14;
    localparam logic [4:0] S_MI_GO   = 5'd15;
    localparam logic [4:0] S_MI_WAIT = 5'd16;
    localparam logic [4:0] S_IFIX    = 5'd17;
    localparam logic [4:0] S_IADD    = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    t_cfg cfg;

    // control state
    logic [4:0]                    r_state;
    logic [4:0]                    n_state;
    logic [EFFORT_W-1:0]           r_integ;
    logic [TICKS_W-1:0]            r_kick_left;
    logic                          r_was_stopped;
    logic signed [DRIVE_WIDTH-1:0] r_last_drive;
    logic                          r_out_valid;

    // per-request datapath
    logic signed [SPEED_W-1:0]     r_tgt;
    logic signed [SPEED_W-1:0]     r_meas;
    logic                          r_fresh;
    logic [SPEED_W-1:0]            r_ref;
    logic [SPEED_W-1:0]            r_mea;
    logic                          r_neg;
    logic                          r_stopped;
    logic                          r_err_neg;
    logic [SPEED_W-1:0]            r_err_mag;
    logic signed [PW-1:0]          r_p;
    logic [EFFORT_W-1:0]           r_v;
    logic                          r_span_neg;
    logic [PULSE_W-1:0]            r_span_mag;
    logic signed [TW-1:0]          r_t;
    logic [PULSE_W-1:0]            r_cmd;
    logic signed [TW-1:0]          r_cmd_s;
    logic                          r_kick;
    logic signed [LW-1:0]          r_drv_pre;
    logic                          r_slewed;
    logic [DRIVE_WIDTH-1:0]        r_out_drive;
    logic                          r_out_slew;
    logic                          r_out_kick;

    // multiplier hookup
    logic                          w_mul_start;
    logic [MUL_A_W-1:0]            w_mul_a;
    logic [MUL_B_W-1:0]            w_mul_b;
    logic                          w_mul_done;
    logic [MUL_P_W-1:0]            w_prod;

    // combinational helpers
    logic signed [PW-1:0]          w_pq;
    logic                          w_prem;
    logic signed [PW-1:0]          w_pfix;
    logic signed [TW-1:0]          w_tq;
    logic                          w_trem;
    logic signed [TW-1:0]          w_tfix;
    logic signed [SW-1:0]          w_esum;
    logic signed [UW-1:0]          w_usum;
    logic signed [UW-1:0]          w_umax_s;
    logic                          w_moving;
    logic                          w_arm;
    logic [TICKS_W-1:0]            w_kl;
    logic signed [LW-1:0]          w_last_x;
    logic signed [LW-1:0]          w_cmd_x;
    logic signed [LW-1:0]          w_step;
    logic signed [LW-1:0]          w_du;
    logic                          w_up;
    logic                          w_dn;
    logic [TW-1:0]                 w_cmd_u;
    logic                          w_load;
    logic                          w_integrate;

    function automatic logic [EFFORT_W-1:0] clamp_effort(input logic signed [SW-1:0] s);
        if (s[SW-1]) begin
            clamp_effort = '0;
        end else if (s > EFF_ONE_S) begin
            clamp_effort = EFFORT_ONE;
        end else begin
            clamp_effort = s[EFFORT_W-1:0];
        end
    endfunction

    pisc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // one shared multiplier: prop gain * |err|, effort * |span|, integral step * |err|
    assign w_mul_start = (r_state == S_MP_GO) || (r_state == S_MU_GO) || (r_state == S_MI_GO);
    assign w_mul_a = (r_state == S_MU_GO) ? MUL_A_W'(r_v) :
                     (r_state == S_MI_GO) ? cfg.integral_step : cfg.prop_gain;
    assign w_mul_b = (r_state == S_MU_GO) ? r_span_mag : r_err_mag;

    pisc_serial_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // floor of signed product over 2^GAIN_SHIFT: -(q + round-up) is ~q + !rem
    assign w_pq   = {1'b0, w_prod[MUL_P_W-1:GAIN_SHIFT]};
    assign w_prem = |w_prod[GAIN_SHIFT-1:0];
    assign w_pfix = r_err_neg ? (~w_pq + PW'(!w_prem)) : w_pq;

    // same for the deadzone map, shift by the effort fraction
    assign w_tq   = {1'b0, w_prod[EFFORT_FRAC+PULSE_W-1:EFFORT_FRAC]};
    assign w_trem = |w_prod[EFFORT_FRAC-1:0];
    assign w_tfix = r_span_neg ? (~w_tq + TW'(!w_trem)) : w_tq;

    // effort term plus integrator, clamped afterwards
    assign w_esum = SW'(r_p) + SW'(r_integ);

    assign w_usum   = UW'(r_t) + UW'(cfg.pulse_offset);
    assign w_umax_s = UW'(cfg.pulse_max);

    // kick-start decision
    assign w_moving = (r_mea >= MOVING_LIMIT);
    assign w_arm    = r_was_stopped && !w_moving && (r_v > KICK_EFFORT_MIN);
    assign w_kl     = w_arm ? cfg.kick_ticks : r_kick_left;

    // slew limiter
    assign w_last_x = LW'(r_last_drive);
    assign w_cmd_x  = LW'(r_cmd_s);
    assign w_step   = LW'(cfg.slew_step);
    assign w_du     = w_cmd_x - w_last_x;
    assign w_up     = (w_du > w_step);
    assign w_dn     = (w_du < -w_step);

    assign w_cmd_u     = {1'b0, r_cmd};
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign w_integrate = !r_stopped && !r_slewed && r_fresh;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (s_axis_tvalid) n_state = S_ABS;
            S_ABS:     n_state = S_ERR;
            S_ERR:     n_state = r_stopped ? S_CMD : S_MP_GO;
            S_MP_GO:   n_state = S_MP_WAIT;
            S_MP_WAIT: if (w_mul_done) n_state = S_PFIX;
            S_PFIX:    n_state = S_EVAL;
            S_EVAL:    n_state = S_KICK;
            S_KICK:    n_state = ((w_kl != '0) || (r_v == '0)) ? S_CMD : S_MU_GO;
            S_MU_GO:   n_state = S_MU_WAIT;
            S_MU_WAIT: if (w_mul_done) n_state = S_UFIX;
            S_UFIX:    n_state = S_UADD;
            S_UADD:    n_state = S_CMD;
            S_CMD:     n_state = S_SLEW;
            S_SLEW:    n_state = S_SAT;
            S_SAT:     n_state = w_integrate ? S_MI_GO : S_DONE;
            S_MI_GO:   n_state = S_MI_WAIT;
            S_MI_WAIT: if (w_mul_done) n_state = S_IFIX;
            S_IFIX:    n_state = S_IADD;
            S_IADD:    n_state = S_DONE;
            S_DONE:    if (w_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control state and controller memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_integ       <= '0;
            r_kick_left   <= '0;
            r_was_stopped <= 1'b1;
            r_last_drive  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_ERR: begin
                    // zero target: drop integrator and kick, mark stopped
                    if (r_stopped) begin
                        r_integ       <= '0;
                        r_kick_left   <= '0;
                        r_was_stopped <= 1'b1;
                    end
                end
                S_KICK: begin
                    if (w_arm || w_moving) begin
                        r_was_stopped <= 1'b0;
                    end
                    r_kick_left <= (w_kl != '0) ? (w_kl - 1'b1) : w_kl;
                end
                S_SAT: begin
                    if (r_drv_pre > DMAX) begin
                        r_last_drive <= DMAX[DRIVE_WIDTH-1:0];
                    end else if (r_drv_pre < NDMAX) begin
                        r_last_drive <= NDMAX[DRIVE_WIDTH-1:0];
                    end else begin
                        r_last_drive <= r_drv_pre[DRIVE_WIDTH-1:0];
                    end
                end
                S_IADD: r_integ <= clamp_effort(w_esum);
                default: begin
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tgt   <= s_axis_tdata[SPEED_W-1:0];
                r_meas  <= s_axis_tdata[2*SPEED_W-1:SPEED_W];
                r_fresh <= s_axis_tuser[0];
            end
            S_ABS: begin
                r_ref     <= r_tgt[SPEED_W-1] ? (~r_tgt + 1'b1) : r_tgt;
                r_mea     <= r_meas[SPEED_W-1] ? (~r_meas + 1'b1) : r_meas;
                r_neg     <= r_tgt[SPEED_W-1];
                r_stopped <= (r_tgt == '0);
            end
            S_ERR: begin
                r_err_neg <= (r_ref < r_mea);
                r_err_mag <= (r_ref < r_mea) ? (r_mea - r_ref) : (r_ref - r_mea);
                r_cmd     <= '0;
                r_kick    <= 1'b0;
            end
            S_PFIX: r_p <= w_pfix;
            S_EVAL: r_v <= clamp_effort(w_esum);
            S_KICK: begin
                r_span_neg <= (cfg.pulse_max < cfg.pulse_offset);
                r_span_mag <= (cfg.pulse_max < cfg.pulse_offset) ?
                              (cfg.pulse_offset - cfg.pulse_max) :
                              (cfg.pulse_max - cfg.pulse_offset);
                if (w_kl != '0) begin
                    r_kick <= 1'b1;
                    r_cmd  <= (cfg.kick_pulse > cfg.pulse_max) ? cfg.pulse_max : cfg.kick_pulse;
                end else begin
                    r_kick <= 1'b0;
                    r_cmd  <= '0;
                end
            end
            S_UFIX: r_t <= w_tfix;
            S_UADD: r_cmd <= (w_usum > w_umax_s) ? cfg.pulse_max : w_usum[PULSE_W-1:0];
            S_CMD:  r_cmd_s <= r_neg ? (~w_cmd_u + 1'b1) : w_cmd_u;
            S_SLEW: begin
                r_slewed  <= w_up || w_dn;
                r_drv_pre <= w_up ? (w_last_x + w_step) :
                             w_dn ? (w_last_x - w_step) : w_cmd_x;
            end
            S_IFIX: r_p <= w_pfix;
            default: begin
            end
        endcase
        if (w_load) begin
            r_out_drive <= r_last_drive;
            r_out_slew  <= r_slewed;
            r_out_kick  <= r_kick;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_drive);
    assign m_axis_tuser  = {r_out_kick, r_out_slew};

`ifndef ASSERT_OFF
    // an accepted request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    // the delivered drive is the stored last drive
    a_out_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid && (m_axis_tdata[DRIVE_WIDTH-1:0] == r_last_drive))
        else $error("result drive differs from stored drive");

    // kicking always leaves the stopped flag clear
    a_kick_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMD) && r_kick |-> !r_was_stopped)
        else $error("kick while still marked stopped");

    // integrator stays inside the effort range
    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_integ <= EFFORT_ONE))
        else $error("integrator out of range");
`endif

endmodule
